FILE: src/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    // Operation codes carried by an input request
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_VIEW       = 3'd4
    } opcode_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_VIEW_RD,
        BK_VIEW_WR
    } back_state_t;

    // Decoded command handed from the front end to the back end
    typedef struct packed {
        opcode_t                   op;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

endpackage

FILE: src/bdq_front.sv
// Front end: accepts requests, drops meaningless opcodes, queues commands.
module bdq_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [2:0]      s_opcode,
    input  logic signed [31:0] s_value,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output bdq_pkg::cmd_t   cmd
);
    import bdq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       legal;
    logic       do_wr;
    logic       do_rd;

    // Classify the opcode: only the five defined operations enter the queue
    always_comb begin
        case (s_opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK, OP_VIEW: legal = 1'b1;
            default: legal = 1'b0;
        endcase
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_wr     = s_valid && s_ready && legal;
    assign do_rd     = cmd_valid && cmd_ready;

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        fill_next   = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 2'd1;
        end else if (!do_wr && do_rd) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold the decoded command in the queue slot
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= '{op: opcode_t'(s_opcode), value: s_value};
        end
    end

endmodule

FILE: src/bdq_back.sv
// Back end: ring store, head and count, command sequencer and result register.
module bdq_back #(
    parameter int CAPACITY = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  bdq_pkg::cmd_t        cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic signed [31:0]   m_data,
    output logic                 m_last
);
    import bdq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_I   = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] view_idx_reg, view_idx_next;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             out_load;
    status_t          out_status;
    logic signed [DATA_W-1:0] out_data;
    logic             out_last;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [CNT_W-1:0] count_m1;
    logic             is_full;
    logic             is_empty;
    logic             view_last;

    // Ring position of an offset from the head
    function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_I) begin
            sum = sum - CAP_I;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || m_ready;
    assign count_m1  = count_reg - CNT_W'(1);
    assign is_full   = (count_reg >= CAP_C);
    assign is_empty  = (count_reg == '0);
    assign view_last = ((CNT_W'(view_idx_reg) + CNT_W'(1)) == count_reg);

    // Sequence commands: next state, store access and result
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        view_idx_next = view_idx_reg;
        cmd_ready     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_re        = 1'b0;
        mem_raddr     = head_reg;
        out_load      = 1'b0;
        out_status    = ST_OK;
        out_data      = '0;
        out_last      = 1'b1;
        case (state_reg)
            BK_IDLE: begin
                cmd_ready = out_free;
                if (cmd_valid && out_free) begin
                    case (cmd.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                out_status = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (cmd.op == OP_PUSH_FRONT) begin
                                    head_next = (head_reg == '0) ? IDX_TOP
                                                                 : head_reg - IDX_W'(1);
                                    mem_waddr = head_next;
                                end else begin
                                    mem_waddr = ring_slot(head_reg, count_reg[IDX_W-1:0]);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (is_empty) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                count_next = count_m1;
                                state_next = BK_POP;
                                if (cmd.op == OP_POP_FRONT) begin
                                    mem_raddr = head_reg;
                                    head_next = ring_slot(head_reg, IDX_W'(1));
                                end else begin
                                    mem_raddr = ring_slot(head_reg, count_m1[IDX_W-1:0]);
                                end
                            end
                        end
                        OP_VIEW: begin
                            if (is_empty) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                view_idx_next = '0;
                                state_next    = BK_VIEW_RD;
                            end
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            BK_POP: begin
                // Result register was freed when the pop was taken
                out_load   = 1'b1;
                out_data   = rd_data_reg;
                state_next = BK_IDLE;
            end
            BK_VIEW_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = ring_slot(head_reg, view_idx_reg);
                state_next = BK_VIEW_WR;
            end
            BK_VIEW_WR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = rd_data_reg;
                    out_last = view_last;
                    if (view_last) begin
                        state_next = BK_IDLE;
                    end else begin
                        view_idx_next = view_idx_reg + IDX_W'(1);
                        state_next    = BK_VIEW_RD;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= cmd.value;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            view_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            view_idx_reg <= view_idx_next;
        end
    end

    // Result register: load a new result or drop the one taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status;
            out_data_reg   <= out_data;
            out_last_reg   <= out_last;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_data   = out_data_reg;
    assign m_last   = out_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, head_reg} < CAP_I)
        else $error("head index outside ring");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten before taken");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1)
             || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_POP) |-> out_load)
        else $error("pop result not delivered");
`endif

endmodule

FILE: src/bounded_double_ended_queue_top.sv
// Top level of the bounded double-ended queue: front end, command queue, back end.
//
// Bounded double-ended queue of signed 32-bit values held in a ring store of CAPACITY
// entries. Each request carries an opcode (push front, push back, pop front, pop back,
// view) and a value; opcodes 5 to 7 are dropped with no result. A push or pop gives one
// result with last set; a view streams every entry front to back with last on the final
// one, or a single empty status. A two-entry command queue separates request intake from
// execution, so up to two requests are still accepted while a result waits on m_ready.
// With the result side free, a push result is loaded as the back end takes the command and a
// pop result after the registered read of the ring store (BK_POP); a view passes a start
// step and then BK_VIEW_RD and BK_VIEW_WR for each entry, set by the single read port of
// the ring store and its read register.
module bounded_double_ended_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_data,
    output logic                m_last
);
    import bdq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    bdq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_value   (s_value),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    bdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_data    (m_data),
        .m_last    (m_last)
    );

endmodule
